// File: src/srhb_pkg.sv
// Shared constants, types and register codes for the speed ramp H-bridge drive.
// Used by srhb_scale and speed_ramp_hbridge_drive; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package srhb_pkg;

    // ramp time width in ticks (valid range 8 to 32)
    localparam int TIME_BITS   = 24;
    localparam int ELAPSED_W   = TIME_BITS + 1;
    localparam int RAMP_TIME_W = 24;

    // speed, difference and duty widths
    localparam int SPEED_W = 16;
    localparam int DIFF_W  = SPEED_W + 1;
    localparam int DUTY_W  = 15;
    localparam int PROD_W  = DIFF_W + TIME_BITS;
    localparam int STEP_W  = $clog2(DIFF_W + 1);

    // full scale speed, 100 percent in steps of 1/256 percent
    localparam int SPEED_FULL = 25600;
    localparam logic signed [DIFF_W-1:0] FULL_POS = DIFF_W'(SPEED_FULL);
    localparam logic signed [DIFF_W-1:0] FULL_NEG = -FULL_POS;
    localparam logic [DUTY_W-1:0]        DUTY_FULL = DUTY_W'(SPEED_FULL);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = CFG_IDX_W'(1);

    // request command codes
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_SETPOINT = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FINISH
    } state_t;

    // control and status between sequencer and scaling unit
    typedef struct packed {
        logic start;
    } scale_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } scale_stat_t;

endpackage

`default_nettype wire

// File: src/srhb_scale.sv
// Shared scaling unit: one multiply, then a restoring divide one quotient bit per cycle.
// Computes mag * elapsed / length, truncated; needs elapsed <= length and length != 0.
// Depends on srhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srhb_scale
    import srhb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire scale_ctrl_t          ctrl,
    input  wire logic [DIFF_W-1:0]    mag,
    input  wire logic [TIME_BITS-1:0] elapsed,
    input  wire logic [TIME_BITS-1:0] length,
    output scale_stat_t               stat,
    output logic [DIFF_W-1:0]         quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [DIFF_W-1:0]    quot_reg, quot_next;
    logic [TIME_BITS:0]   trial;
    logic                 fits;

    // one divide step: bring down the next dividend bit and try a subtract
    assign trial = {rem_reg, quot_reg[DIFF_W-1]};
    assign fits  = (trial >= {1'b0, length});

    // sequencing of multiply, load and divide steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (ctrl.start)
        begin
            prod_next = PROD_W'(mag) * PROD_W'(elapsed);
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                // top bits are below the divisor since the quotient fits DIFF_W bits
                rem_next  = prod_reg[PROD_W-1 -: TIME_BITS];
                quot_next = prod_reg[DIFF_W-1:0];
                step_next = step_reg + STEP_W'(1);
            end
            else
            begin
                if (fits)
                begin
                    rem_next = TIME_BITS'(trial - {1'b0, length});
                end
                else
                begin
                    rem_next = trial[TIME_BITS-1:0];
                end
                quot_next = {quot_reg[DIFF_W-2:0], fits};
                if (step_reg == STEP_W'(DIFF_W))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

`default_nettype wire

// File: src/speed_ramp_hbridge_drive.sv
// Top level: ramp state, sequencer, clamp, H-bridge duty stage and output register.
// Depends on srhb_pkg and srhb_scale.
`timescale 1ns / 1ps
`default_nettype none

// Linear speed ramp driving an H-bridge. A setpoint request starts a ramp from the present
// speed to target_speed over ramp_time ticks; a tick request advances the ramp by one tick.
// Every request gives one result: the clamped speed, both leg duties and a ramp-done flag.
// A request whose speed lies on the slope of a ramp reaches a valid result through one
// multiply, one load and DIFF_W divide steps in the shared scaling unit, plus sequencer
// steps; a request outside a ramp skips the scaling unit. One request is in work at
// a time; in_ready is high only while the sequencer is idle. The result register frees the
// input side, so a new request may be taken while a result still waits for out_ready.
// Configuration writes are always ready and take effect at once.
module speed_ramp_hbridge_drive
    import srhb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    cmd,
    input  wire logic signed [SPEED_W-1:0] target_speed,
    input  wire logic [RAMP_TIME_W-1:0]  ramp_time,
    // result channel
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [SPEED_W-1:0]    drive_speed,
    output logic [DUTY_W-1:0]            duty_a,
    output logic [DUTY_W-1:0]            duty_b,
    output logic                         ramp_done
);

    state_t state_reg, state_next;

    logic                     brake_mode_reg;
    logic [DUTY_W-1:0]        deadband_reg;

    logic signed [SPEED_W-1:0] cur_speed_reg, cur_speed_next;
    logic signed [SPEED_W-1:0] start_reg, start_next;
    logic signed [SPEED_W-1:0] end_reg, end_next;
    logic [ELAPSED_W-1:0]      elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]      length_reg, length_next;
    logic signed [DIFF_W-1:0]  raw_reg, raw_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [SPEED_W-1:0] speed_out_reg, speed_out_next;
    logic [DUTY_W-1:0]         duty_a_reg, duty_a_next;
    logic [DUTY_W-1:0]         duty_b_reg, duty_b_next;
    logic                      done_out_reg, done_out_next;

    logic                      in_accept;
    logic                      ramp_over;
    logic signed [DIFF_W-1:0]  start_ext;
    logic signed [DIFF_W-1:0]  end_ext;
    logic signed [DIFF_W-1:0]  diff;
    logic                      diff_neg;
    logic [DIFF_W-1:0]         diff_mag;
    logic signed [DIFF_W-1:0]  part;
    logic signed [DIFF_W-1:0]  clamped;
    logic signed [DIFF_W-1:0]  db_pos;
    logic signed [DIFF_W-1:0]  db_neg;
    logic [DUTY_W-1:0]         idle_duty;
    logic signed [DIFF_W-1:0]  drive_duty;

    scale_ctrl_t               scale_ctrl;
    scale_stat_t               scale_stat;
    logic [DIFF_W-1:0]         scale_quot;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_mode_reg <= 1'b1;
            deadband_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BRAKE_MODE: brake_mode_reg <= cfg_data[0];
                CFG_DEADBAND:   deadband_reg   <= cfg_data[DUTY_W-1:0];
                default:        ;
            endcase
        end
    end

    // ramp difference and its magnitude for the scaling unit
    assign start_ext = DIFF_W'(start_reg);
    assign end_ext   = DIFF_W'(end_reg);
    assign diff      = end_ext - start_ext;
    assign diff_neg  = diff[DIFF_W-1];
    assign diff_mag  = diff_neg ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign part      = diff_neg ? -$signed(scale_quot) : $signed(scale_quot);
    assign ramp_over = (length_reg == '0) || (elapsed_reg > ELAPSED_W'(length_reg));

    srhb_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (scale_ctrl),
        .mag     (diff_mag),
        .elapsed (elapsed_reg[TIME_BITS-1:0]),
        .length  (length_reg),
        .stat    (scale_stat),
        .quot    (scale_quot)
    );

    // clamp to full scale and derive the leg duties
    always_comb
    begin
        if (raw_reg > FULL_POS)
        begin
            clamped = FULL_POS;
        end
        else if (raw_reg < FULL_NEG)
        begin
            clamped = FULL_NEG;
        end
        else
        begin
            clamped = raw_reg;
        end
        db_pos     = DIFF_W'(deadband_reg);
        db_neg     = -db_pos;
        idle_duty  = brake_mode_reg ? DUTY_FULL : '0;
        drive_duty = '0;
        priority if (clamped > db_pos)
        begin
            drive_duty  = FULL_POS - clamped;
            duty_a_next = idle_duty;
            duty_b_next = drive_duty[DUTY_W-1:0];
        end
        else if (clamped < db_neg)
        begin
            drive_duty  = FULL_POS + clamped;
            duty_a_next = drive_duty[DUTY_W-1:0];
            duty_b_next = idle_duty;
        end
        else
        begin
            duty_a_next = idle_duty;
            duty_b_next = idle_duty;
        end
    end

    // sequencer and ramp state update
    always_comb
    begin
        state_next       = state_reg;
        cur_speed_next   = cur_speed_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        elapsed_next     = elapsed_reg;
        length_next      = length_reg;
        raw_next         = raw_reg;
        scale_ctrl.start = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        speed_out_next   = speed_out_reg;
        done_out_next    = done_out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd == CMD_SETPOINT)
                    begin
                        start_next   = cur_speed_reg;
                        end_next     = target_speed;
                        length_next  = TIME_BITS'(ramp_time);
                        elapsed_next = '0;
                    end
                    else if (elapsed_reg <= ELAPSED_W'(length_reg))
                    begin
                        elapsed_next = elapsed_reg + ELAPSED_W'(1);
                    end
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (ramp_over)
                begin
                    raw_next   = end_ext;
                    state_next = ST_FINISH;
                end
                else
                begin
                    scale_ctrl.start = 1'b1;
                    state_next       = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (scale_stat.done && !scale_stat.busy)
                begin
                    raw_next   = start_ext + part;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cur_speed_next = clamped[SPEED_W-1:0];
                    speed_out_next = clamped[SPEED_W-1:0];
                    done_out_next  = (elapsed_reg > ELAPSED_W'(length_reg));
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cur_speed_reg <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            elapsed_reg   <= ELAPSED_W'(1);
            length_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_speed_reg <= cur_speed_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            elapsed_reg   <= elapsed_next;
            length_reg    <= length_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        raw_reg       <= raw_next;
        speed_out_reg <= speed_out_next;
        done_out_reg  <= done_out_next;
        if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
        begin
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_speed = speed_out_reg;
    assign duty_a      = duty_a_reg;
    assign duty_b      = duty_b_reg;
    assign ramp_done   = done_out_reg;

endmodule

`default_nettype wire
